[design/b2da_pkg.sv]
// shared types, constants and the power-of-ten lookup for the decimal ascii converter
`timescale 1ns / 1ps
`default_nettype none

package b2da_pkg;

    localparam int VALUE_W    = 16;
    localparam int NUM_DIGITS = 5;
    localparam int DIGIT_W    = 4;
    localparam int CHAR_W     = 6;
    localparam int REM_W      = VALUE_W + 1;

    // digit position, 0 is the ten-thousands digit
    typedef logic [2:0] digit_idx_t;

    localparam digit_idx_t FIRST_POS = 3'd0;
    localparam digit_idx_t LAST_POS  = 3'd4;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;
    localparam logic [DIGIT_W-1:0] MAX_DIGIT = 4'd9;

    // data handed from one digit cell to the next
    typedef struct packed {
        logic [VALUE_W-1:0]                     rem;
        logic [NUM_DIGITS-1:0][DIGIT_W-1:0]     digits;
    } b2da_beat_t;

    // weight of each digit position
    function automatic logic [REM_W-1:0] pow10(input digit_idx_t idx);
        logic [REM_W-1:0] p;
        case (idx)
            3'd0:    p = 17'd10000;
            3'd1:    p = 17'd1000;
            3'd2:    p = 17'd100;
            3'd3:    p = 17'd10;
            3'd4:    p = 17'd1;
            default: p = 17'd1;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

[design/b2da_digit_cell.sv]
// one digit cell: extracts the digit at its position and passes the remainder on
`timescale 1ns / 1ps
`default_nettype none

module b2da_digit_cell import b2da_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire digit_idx_t cell_idx,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire b2da_beat_t in_beat,
    output logic            out_valid,
    input  wire logic       out_ready,
    output b2da_beat_t      out_beat
);

    logic       valid_reg;
    logic       valid_next;
    b2da_beat_t beat_reg;
    b2da_beat_t beat_next;
    logic [REM_W-1:0]   weight;
    logic [DIGIT_W-1:0] digit;

    // cell takes a new beat when empty or when its beat moves on
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

    // digit by parallel compares against the multiples of the weight
    always_comb begin
        weight = pow10(cell_idx);
        digit  = '0;
        for (int k = 1; k <= 9; k++) begin
            if ({1'b0, in_beat.rem} >= 17'(k) * weight) begin
                digit = digit + 4'd1;
            end
        end
        beat_next                 = in_beat;
        beat_next.digits[cell_idx] = digit;
        beat_next.rem             = VALUE_W'({1'b0, in_beat.rem} - 17'(digit) * weight);
        valid_next                = in_ready ? in_valid : valid_reg;
    end

    // control register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload register
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            beat_reg <= beat_next;
        end
    end

    // remainder stays below this position's weight
    a_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> ({1'b0, beat_reg.rem} < weight))
        else $error("remainder not below digit weight");

    // extracted digit is decimal
    a_digit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (beat_reg.digits[cell_idx] <= MAX_DIGIT))
        else $error("digit out of decimal range");

    // a stalled beat stays in place
    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !out_ready) |=> (valid_reg && $stable(beat_reg)))
        else $error("stalled beat changed or dropped");

endmodule

`default_nettype wire

[design/b2da_serializer.sv]
// output register that streams the digits as ascii characters without leading zeros
`timescale 1ns / 1ps
`default_nettype none

module b2da_serializer import b2da_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire b2da_beat_t         in_beat,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [CHAR_W-1:0]       out_char,
    output logic                    out_last
);

    logic                               busy_reg;
    logic                               busy_next;
    digit_idx_t                         pos_reg;
    digit_idx_t                         pos_next;
    logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits_reg;
    digit_idx_t                         first_pos;
    logic                               load;

    // highest nonzero digit, or the units digit for zero
    always_comb begin
        first_pos = LAST_POS;
        for (int i = NUM_DIGITS - 1; i >= 0; i--) begin
            if (in_beat.digits[i] != '0) begin
                first_pos = digit_idx_t'(i);
            end
        end
    end

    assign out_valid = busy_reg;
    assign out_last  = (pos_reg == LAST_POS);
    assign out_char  = ASCII_ZERO + CHAR_W'(digits_reg[pos_reg]);
    assign in_ready  = !busy_reg || (out_ready && out_last);
    assign load      = in_ready && in_valid;

    // next position and busy flag
    always_comb begin
        busy_next = busy_reg;
        pos_next  = pos_reg;
        if (load) begin
            busy_next = 1'b1;
            pos_next  = first_pos;
        end else if (busy_reg && out_ready) begin
            if (out_last) begin
                busy_next = 1'b0;
            end else begin
                pos_next = pos_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pos_reg  <= FIRST_POS;
        end else begin
            busy_reg <= busy_next;
            pos_reg  <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            digits_reg <= in_beat.digits;
        end
    end

    // position never runs past the units digit
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (pos_reg <= LAST_POS))
        else $error("digit position out of range");

    // a value keeps streaming until its last character
    a_no_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && out_ready && !out_last) |=> busy_reg)
        else $error("character stream broke before last");

    // first character of a value is not a leading zero
    a_no_lead_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && first_pos != LAST_POS) |=> (out_char != ASCII_ZERO))
        else $error("leading zero emitted");

endmodule

`default_nettype wire

[design/binary_to_decimal_ascii_top.sv]
// top level of the 16-bit binary to decimal ascii converter
//
// usage:
//   slave channel s_*: one beat carries a 16-bit unsigned value in s_tdata.
//   master channel m_*: one beat per decimal character, most significant first,
//   leading zeros dropped, so a value gives one to five beats; m_tlast marks
//   the units digit. zero gives the single character '0'.
//   a row of five digit cells, one per decimal position, each strips its digit
//   with parallel compares and hands the remainder to the next cell every cycle
//   unless that cell stalls. the last stage is an output register that walks
//   the digits out. the input beat passes through the five cell registers and
//   then the output register before its first character. the output gives one
//   character per cycle while m_tready is high; a value holds the output until
//   its last character, so the single output channel sets the sustained rate.
//   while the receiver stalls, up to five further values wait in the cells
//   and s_tready stays high until they are all full.
//   reset (aresetn low, synchronous) empties every cell and the output register.
`timescale 1ns / 1ps
`default_nettype none

module binary_to_decimal_ascii_top import b2da_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] value
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [5:0] digit_char, [7:6] zero
    output logic             m_tlast
);

    logic       link_valid [NUM_DIGITS+1];
    logic       link_ready [NUM_DIGITS+1];
    b2da_beat_t link_beat  [NUM_DIGITS+1];
    logic [CHAR_W-1:0] digit_char;

    // head of the cell row
    assign link_valid[0]        = s_tvalid;
    assign s_tready             = link_ready[0];
    assign link_beat[0].rem     = s_tdata;
    assign link_beat[0].digits  = '0;

    // row of digit cells
    for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_cell
        b2da_digit_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cell_idx  (digit_idx_t'(g)),
            .in_valid  (link_valid[g]),
            .in_ready  (link_ready[g]),
            .in_beat   (link_beat[g]),
            .out_valid (link_valid[g+1]),
            .out_ready (link_ready[g+1]),
            .out_beat  (link_beat[g+1])
        );
    end

    // character output stage
    b2da_serializer u_ser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (link_valid[NUM_DIGITS]),
        .in_ready  (link_ready[NUM_DIGITS]),
        .in_beat   (link_beat[NUM_DIGITS]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (digit_char),
        .out_last  (m_tlast)
    );

    assign m_tdata = {2'b00, digit_char};

endmodule

`default_nettype wire

[dv/binary_to_decimal_ascii_top_test.sv]
// self-checking testbench for the 16-bit binary to decimal ascii converter
`timescale 1ns / 1ps

module binary_to_decimal_ascii_top_test;
    import b2da_pkg::*;

    localparam int RANDOM_VALUES  = 450;
    localparam int IDLE_LIMIT     = 2000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int HOLD_CYCLES    = 300;

    // receiver stall styles
    localparam int RX_ALWAYS   = 0;
    localparam int RX_COIN     = 1;
    localparam int RX_SPARSE   = 2;
    localparam int RX_PERIODIC = 3;

    // one expected output character
    typedef struct {
        logic [CHAR_W-1:0] digit_char;
        logic              is_last;
    } dec_char_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [VALUE_W-1:0]   s_tdata = '0;     // [15:0] value
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [7:0]           m_tdata;          // [5:0] digit_char, [7:6] zero
    logic                 m_tlast;

    logic [VALUE_W-1:0]   pending_values[$];
    dec_char_t            expected_chars[$];

    logic                 s_beat_taken = 1'b0;
    int                   fail_count = 0;
    int                   values_taken = 0;
    int                   idle_cycles = 0;
    int                   burst_left = 1;
    int                   gap_left = 0;
    int                   rx_style = RX_ALWAYS;
    int                   rx_style_left = 40;
    int                   rx_phase = 0;
    int                   hold_left = 0;
    int                   holds_done = 0;

    binary_to_decimal_ascii_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // 100 MHz clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // split a value into decimal characters, leading zeros dropped
    function automatic void push_decimal_chars(input logic [VALUE_W-1:0] value);
        int        digit[NUM_DIGITS];
        int        rest;
        int        top;
        dec_char_t c;
        rest = value;
        for (int i = NUM_DIGITS - 1; i >= 0; i--) begin
            digit[i] = rest % 10;
            rest = rest / 10;
        end
        top = NUM_DIGITS - 1;
        for (int i = NUM_DIGITS - 1; i >= 0; i--) begin
            if (digit[i] != 0) begin
                top = i;
            end
        end
        for (int i = top; i < NUM_DIGITS; i++) begin
            c.digit_char = ASCII_ZERO + CHAR_W'(digit[i]);
            c.is_last    = (i == NUM_DIGITS - 1);
            expected_chars.push_back(c);
        end
    endfunction

    // one line per mismatch
    task automatic report_mismatch(input string what, input int exp_val, input int got_val);
        fail_count++;
        $display("%0t mismatch: %s expected %0d got %0d", $realtime, what, exp_val, got_val);
    endtask

    // value with a chosen digit count, or boundary and full-range picks
    function automatic logic [VALUE_W-1:0] random_value();
        int ndig;
        int lo;
        int hi;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            return VALUE_W'($urandom);
        end
        if (pick == 1) begin
            lo = 1;
            for (int i = 0; i < $urandom_range(0, 4); i++) begin
                lo = lo * 10;
            end
            return VALUE_W'(lo + $urandom_range(0, 2) - 1);
        end
        ndig = $urandom_range(1, NUM_DIGITS);
        lo = 1;
        for (int i = 1; i < ndig; i++) begin
            lo = lo * 10;
        end
        hi = (ndig == NUM_DIGITS) ? 65535 : lo * 10 - 1;
        if (ndig == 1) begin
            lo = 0;
        end
        return VALUE_W'($urandom_range(lo, hi));
    endfunction

    // sender: bursts of beats with random gaps
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_beat_taken) begin
            // beat still waiting for s_tready
        end else if (gap_left > 0) begin
            s_tvalid <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (pending_values.size() > 0) begin
            s_tdata  <= pending_values.pop_front();
            s_tvalid <= 1'b1;
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 12);
                gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // receiver: changing stall styles plus two long hold-offs
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if ((holds_done == 0 && values_taken >= 120) ||
                     (holds_done == 1 && values_taken >= 330)) begin
            m_tready   <= 1'b0;
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end else begin
            case (rx_style)
                RX_ALWAYS:   m_tready <= 1'b1;
                RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE:   m_tready <= ($urandom_range(0, 3) != 0);
                RX_PERIODIC: m_tready <= (rx_phase % 3 == 0);
                default:     m_tready <= 1'b1;
            endcase
            rx_phase <= rx_phase + 1;
            if (rx_style_left == 0) begin
                rx_style      <= $urandom_range(RX_ALWAYS, RX_PERIODIC);
                rx_style_left <= $urandom_range(10, 80);
            end else begin
                rx_style_left <= rx_style_left - 1;
            end
        end
    end

    // monitor: predict on input beats, check output beats
    always @(posedge aclk) begin
        dec_char_t want;
        s_beat_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_chars.size() == 0) begin
                    report_mismatch("unexpected character beat", -1, m_tdata);
                end else begin
                    want = expected_chars.pop_front();
                    if (m_tdata[CHAR_W-1:0] !== want.digit_char) begin
                        report_mismatch("digit_char", want.digit_char, m_tdata[CHAR_W-1:0]);
                    end
                    if (m_tdata[7:CHAR_W] !== '0) begin
                        report_mismatch("tdata padding", 0, m_tdata[7:CHAR_W]);
                    end
                    if (m_tlast !== want.is_last) begin
                        report_mismatch("tlast", want.is_last, m_tlast);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                push_decimal_chars(s_tdata);
                values_taken <= values_taken + 1;
            end
        end
    end

    // watchdog on cycles without any beat
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // stimulus, reset and end of run
    initial begin
        // directed: zero, digit-count boundaries, bit patterns, full scale
        pending_values = '{16'd0, 16'd1, 16'd9, 16'd10, 16'd11, 16'd99, 16'd100,
                           16'd101, 16'd999, 16'd1000, 16'd9999, 16'd10000,
                           16'd10001, 16'd65535, 16'h5555, 16'hAAAA, 16'h8000,
                           16'h0001, 16'd12345, 16'd60000, 16'd30303, 16'd50005,
                           16'd0, 16'd7};
        for (int i = 0; i < RANDOM_VALUES; i++) begin
            pending_values.push_back(random_value());
        end

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_values.size() != 0 || s_tvalid) begin
            @(posedge aclk);
        end
        while (expected_chars.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[sim.f]
design/b2da_pkg.sv
design/b2da_digit_cell.sv
design/b2da_serializer.sv
design/binary_to_decimal_ascii_top.sv
dv/binary_to_decimal_ascii_top_test.sv
